@@ rtl/core/rpp_pkg.sv @@
// rpp_pkg: types and constants shared by the vertex projection pipeline.
// Beat layouts for vertices and screen points, register map codes.
`timescale 1ns / 1ps
package rpp_pkg;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_height;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
  } point_t;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_COS_YAW     = 3'd0;
  localparam logic [2:0] REG_SIN_YAW     = 3'd1;
  localparam logic [2:0] REG_COS_PITCH   = 3'd2;
  localparam logic [2:0] REG_SIN_PITCH   = 3'd3;
  localparam logic [2:0] REG_OFFSET_X    = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd5;
  localparam logic [2:0] REG_DEPTH_BIAS  = 3'd6;
  localparam logic [2:0] REG_ZOOM_FACTOR = 3'd7;

  localparam logic [15:0] RST_COS   = 16'd16384;
  localparam logic [15:0] RST_ZOOM  = 16'd20;
  localparam logic [20:0] PROJ_GAIN = 21'd25;

  // quotient bits kept; anything at or above 2^QB saturates the output
  localparam int QB = 17;
  localparam int RW = 52;   // rotated coordinate width
  localparam int NW = 73;   // scaled numerator width

endpackage

@@ rtl/core/rotate_project_point_top.sv @@
// rotate_project_point_top: translate, rotate and perspective-project map vertices.
// Depends on rpp_pkg for beat types and register codes.
`timescale 1ns / 1ps
// One vertex may be started in every clock cycle (busy is always low). Each
// vertex gives one screen point on result, marked by done, after passing
// nine stages of translation, rotation and scaling, then the 17-stage
// restoring divider, one quotient bit per stage, and one output register
// that saturates and adds the half window. The receiver cannot stall.
// The user must write the registers through the APB port only while no
// vertex is in flight; the block itself does not enforce this.
module rotate_project_point_top #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  rpp_pkg::vertex_t          vertex,
  output logic                      done,
  output rpp_pkg::point_t           result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rpp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import rpp_pkg::*;

  localparam int HALF_W = SCREEN_WIDTH / 2;
  localparam int HALF_H = SCREEN_HEIGHT / 2;
  localparam int NSTG   = QB;
  localparam int LAT    = 9 + NSTG;

  logic signed [15:0] cos_yaw, sin_yaw, cos_pitch, sin_pitch;
  logic signed [15:0] offset_x, offset_y, depth_bias;
  logic [15:0] zoom_factor;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_yaw     <= RST_COS;
      sin_yaw     <= '0;
      cos_pitch   <= RST_COS;
      sin_pitch   <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
      depth_bias  <= '0;
      zoom_factor <= RST_ZOOM;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COS_YAW:     cos_yaw     <= pwdata[15:0];
        REG_SIN_YAW:     sin_yaw     <= pwdata[15:0];
        REG_COS_PITCH:   cos_pitch   <= pwdata[15:0];
        REG_SIN_PITCH:   sin_pitch   <= pwdata[15:0];
        REG_OFFSET_X:    offset_x    <= pwdata[15:0];
        REG_OFFSET_Y:    offset_y    <= pwdata[15:0];
        REG_DEPTH_BIAS:  depth_bias  <= pwdata[15:0];
        REG_ZOOM_FACTOR: zoom_factor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COS_YAW:     prdata = 32'(cos_yaw);
      REG_SIN_YAW:     prdata = 32'(sin_yaw);
      REG_COS_PITCH:   prdata = 32'(cos_pitch);
      REG_SIN_PITCH:   prdata = 32'(sin_pitch);
      REG_OFFSET_X:    prdata = 32'(offset_x);
      REG_OFFSET_Y:    prdata = 32'(offset_y);
      REG_DEPTH_BIAS:  prdata = 32'(depth_bias);
      REG_ZOOM_FACTOR: prdata = {16'd0, zoom_factor};
      default:         prdata = '0;
    endcase
  end

  // valid bits, one per stage
  logic [LAT:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[LAT-1:0], start};
  end
  assign done = vld[LAT];

  // s1: translate
  logic signed [17:0] a1, b1, c1;
  // s2: yaw products
  logic signed [33:0] p_cb, p_sa, p_ca, p_sb;
  logic signed [17:0] c2;
  // s3: yaw sums
  logic signed [34:0] t3, rx3;
  logic signed [17:0] c3;
  // s4: pitch products
  logic signed [50:0] m_st, m_ct;
  logic signed [47:0] m_cc, m_sc;
  logic signed [34:0] rx4;
  // s5: rotated point
  logic signed [RW-1:0] rx5, ry5, rz5;
  // s6: magnitudes and signs
  logic [RW-1:0] mx6, my6, d6;
  logic          nx6, ny6;
  // s7: partial products
  logic [46:0] lox7, hix7, loy7, hiy7;
  logic [RW-1:0] d7;
  logic          nx7, ny7;
  // s8: scaled numerators
  logic [NW-1:0] nx8, ny8;
  logic [RW-1:0] d8;
  logic          sx8, sy8;

  logic signed [31:0] c28;
  logic signed [RW-1:0] den5;
  logic [20:0] gain;
  assign c28  = {c3, 14'd0};
  assign den5 = (rz5 == '0) ? (RW'(10) <<< 28) : rz5;
  assign gain = 21'(zoom_factor) * PROJ_GAIN;

  // divider pipe, entry index 0, exit index NSTG
  logic [NW-1:0] rem_x [0:NSTG];
  logic [NW-1:0] rem_y [0:NSTG];
  logic [QB-1:0] quo_x [0:NSTG];
  logic [QB-1:0] quo_y [0:NSTG];
  logic [RW-1:0] dv    [0:NSTG];
  logic          ngx   [0:NSTG];
  logic          ngy   [0:NSTG];
  logic          ovx   [0:NSTG];
  logic          ovy   [0:NSTG];

  always_ff @(posedge clk) begin
    a1 <= 18'(vertex.vertex_x) - 18'(offset_x);
    b1 <= 18'(vertex.vertex_height) + 18'(depth_bias);
    c1 <= -18'(vertex.vertex_y) - 18'(offset_y);

    p_cb <= cos_yaw * b1;
    p_sa <= sin_yaw * a1;
    p_ca <= cos_yaw * a1;
    p_sb <= sin_yaw * b1;
    c2   <= c1;

    t3  <= 35'(p_cb) + 35'(p_sa);
    rx3 <= 35'(p_ca) - 35'(p_sb);
    c3  <= c2;

    m_st <= sin_pitch * t3;
    m_ct <= cos_pitch * t3;
    m_cc <= cos_pitch * c28;
    m_sc <= sin_pitch * c28;
    rx4  <= rx3;

    rx5 <= RW'(rx4) <<< 14;
    ry5 <= RW'(m_st) + RW'(m_cc);
    rz5 <= RW'(m_ct) - RW'(m_sc);

    mx6 <= rx5[RW-1] ? RW'(-rx5) : RW'(rx5);
    my6 <= ry5[RW-1] ? RW'(-ry5) : RW'(ry5);
    d6  <= den5[RW-1] ? RW'(-den5) : RW'(den5);
    nx6 <= rx5[RW-1] ^ den5[RW-1];
    ny6 <= ry5[RW-1] ^ den5[RW-1];

    lox7 <= 47'(mx6[25:0]) * 47'(gain);
    hix7 <= 47'(mx6[RW-1:26]) * 47'(gain);
    loy7 <= 47'(my6[25:0]) * 47'(gain);
    hiy7 <= 47'(my6[RW-1:26]) * 47'(gain);
    d7   <= d6;
    nx7  <= nx6;
    ny7  <= ny6;

    nx8 <= NW'(lox7) + (NW'(hix7) << 26);
    ny8 <= NW'(loy7) + (NW'(hiy7) << 26);
    d8  <= d7;
    sx8 <= nx7;
    sy8 <= ny7;

    // quotient too large for the kept bits -> saturate later
    rem_x[0] <= nx8;
    rem_y[0] <= ny8;
    quo_x[0] <= '0;
    quo_y[0] <= '0;
    dv[0]    <= d8;
    ngx[0]   <= sx8;
    ngy[0]   <= sy8;
    ovx[0]   <= nx8 >= (NW'(d8) << QB);
    ovy[0]   <= ny8 >= (NW'(d8) << QB);
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar i = 0; i < NSTG; i++) begin : g_div
    localparam int K = NSTG - 1 - i;
    logic [NW-1:0] dsh;
    logic          gex, gey;
    assign dsh = NW'(dv[i]) << K;
    assign gex = rem_x[i] >= dsh;
    assign gey = rem_y[i] >= dsh;
    always_ff @(posedge clk) begin
      rem_x[i+1] <= gex ? rem_x[i] - dsh : rem_x[i];
      rem_y[i+1] <= gey ? rem_y[i] - dsh : rem_y[i];
      quo_x[i+1] <= {quo_x[i][QB-2:0], gex};
      quo_y[i+1] <= {quo_y[i][QB-2:0], gey};
      dv[i+1]    <= dv[i];
      ngx[i+1]   <= ngx[i];
      ngy[i+1]   <= ngy[i];
      ovx[i+1]   <= ovx[i];
      ovy[i+1]   <= ovy[i];
    end
  end

  function automatic logic signed [15:0] place(input logic [QB-1:0] q, input logic neg,
                                               input logic ovf, input logic [13:0] half);
    logic signed [QB+2:0] s;
    s = neg ? (QB+3)'(half) - (QB+3)'(q) : (QB+3)'(half) + (QB+3)'(q);
    if (ovf)             place = neg ? 16'sh8000 : 16'sh7fff;
    else if (s > 32767)  place = 16'sh7fff;
    else if (s < -32768) place = 16'sh8000;
    else                 place = s[15:0];
  endfunction

  always_ff @(posedge clk) begin
    result.screen_x <= place(quo_x[NSTG], ngx[NSTG], ovx[NSTG], 14'(HALF_W));
    result.screen_y <= place(quo_y[NSTG], ngy[NSTG], ovy[NSTG], 14'(HALF_H));
  end

endmodule
